/* src/lbmq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbmq_pkg
// Beat types and status codes shared by the linked-block message queue.
// ----------------------------------------------------------------------------
package lbmq_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_EMPTY = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_LONG  = 3'd3;
  localparam status_t ST_SMALL = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] data;
    logic        last;
    logic [4:0]  capacity;
  } in_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic        final_res;
    status_t     status;
    logic [4:0]  length;
  } out_item_t;

endpackage
`default_nettype wire

/* src/linked_block_message_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// linked_block_message_queue
// Message queue over a pool of fixed-size blocks with a LIFO free list and a
// FIFO list of complete messages.
//
//   channel  ports                          direction
//   input    start, busy, in_item           one write word or one read request
//   result   out_valid, out_item            one beat per cycle, no back-pressure
//   config   cfg_we, cfg_wdata              max_words, written at once
//
// A write word that needs no list read finishes in S_IDLE; one that pops a
// recycled free block or closes a message also passes S_WFIN (one meta memory
// read or link write). A read that streams reads its header from the meta
// memory in S_RHDR, then one payload word per cycle from the payload memory.
// A read refused on capacity or empty list is answered in S_IDLE, one refused
// on the header length in S_RHDR. Reset is synchronous; never-used blocks are
// tracked by a fill mark, so no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module linked_block_message_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BLOCK_WORDS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lbmq_pkg::in_item_t in_item,
  output logic                    out_valid,
  output lbmq_pkg::out_item_t     out_item,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_wdata
);
  import lbmq_pkg::*;

  localparam int BW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CW  = $clog2(BLOCK_WORDS + 1);
  localparam int LW  = (CW > 5) ? CW : 5;
  localparam int PD  = QUEUE_DEPTH * BLOCK_WORDS;
  localparam int AW  = (PD > 1) ? $clog2(PD) : 1;
  localparam int MA  = $clog2(QUEUE_DEPTH);
  localparam int MW  = BW + CW;
  localparam logic [BW-1:0] NIL = BW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_WFIN, S_RHDR, S_RSTREAM} state_t;

  state_t          state_r, state_nxt;
  logic [4:0]      max_words_r, max_words_nxt;
  logic [BW-1:0]   free_head_r, free_head_nxt;
  logic [BW-1:0]   fresh_r, fresh_nxt;
  logic [BW-1:0]   ready_head_r, ready_head_nxt;
  logic [BW-1:0]   ready_tail_r, ready_tail_nxt;
  logic [CW-1:0]   tail_len_r, tail_len_nxt;
  logic [BW-1:0]   fill_block_r, fill_block_nxt;
  logic [CW-1:0]   fill_count_r, fill_count_nxt;
  logic            fill_busy_r, fill_busy_nxt;
  logic            fill_drop_r, fill_drop_nxt;
  logic            pop_pend_r, pop_pend_nxt;
  logic            enq_pend_r, enq_pend_nxt;
  logic [CW-1:0]   enq_len_r, enq_len_nxt;
  logic [BW-1:0]   rd_blk_r, rd_blk_nxt;
  logic [BW-1:0]   rd_link_r, rd_link_nxt;
  logic [CW-1:0]   rd_len_r, rd_len_nxt;
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [4:0]      rd_cap_r, rd_cap_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic            meta_we;
  logic [MA-1:0]   meta_waddr, meta_raddr;
  logic [MW-1:0]   meta_wdata, meta_rdata;
  logic            pay_we;
  logic [AW-1:0]   pay_waddr, pay_raddr;
  logic [63:0]     pay_wdata, pay_rdata;

  logic            accept;
  logic [LW-1:0]   lim;
  logic [BW-1:0]   blk;
  logic [CW-1:0]   cnt1;
  logic            rd_final;

  function automatic logic [AW-1:0] pay_addr(input logic [BW-1:0] b, input logic [CW-1:0] w);
    return AW'(AW'(b) * AW'(BLOCK_WORDS) + AW'(w));
  endfunction

  function automatic out_item_t mk_res(input logic [63:0] w, input logic fin,
                                       input status_t st, input logic [CW-1:0] len);
    out_item_t r;
    r.word      = w;
    r.final_res = fin;
    r.status    = st;
    r.length    = 5'(len);
    return r;
  endfunction

  lbmq_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  lbmq_ram #(.WIDTH(64), .DEPTH(PD)) u_payload (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign lim       = (LW'(max_words_r) < LW'(BLOCK_WORDS)) ? LW'(max_words_r)
                                                            : LW'(BLOCK_WORDS);
  assign blk       = fill_busy_r ? fill_block_r : free_head_r;
  assign cnt1      = fill_count_r + CW'(1);
  assign rd_final  = ((rd_cnt_r + CW'(1)) == rd_len_r);

  always_comb begin
    state_nxt      = state_r;
    max_words_nxt  = cfg_we ? cfg_wdata : max_words_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    ready_head_nxt = ready_head_r;
    ready_tail_nxt = ready_tail_r;
    tail_len_nxt   = tail_len_r;
    fill_block_nxt = fill_block_r;
    fill_count_nxt = fill_count_r;
    fill_busy_nxt  = fill_busy_r;
    fill_drop_nxt  = fill_drop_r;
    pop_pend_nxt   = pop_pend_r;
    enq_pend_nxt   = enq_pend_r;
    enq_len_nxt    = enq_len_r;
    rd_blk_nxt     = rd_blk_r;
    rd_link_nxt    = rd_link_r;
    rd_len_nxt     = rd_len_r;
    rd_idx_nxt     = rd_idx_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_cap_nxt     = rd_cap_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    meta_we        = 1'b0;
    meta_waddr     = '0;
    meta_wdata     = '0;
    meta_raddr     = '0;
    pay_we         = 1'b0;
    pay_waddr      = '0;
    pay_wdata      = in_item.data;
    pay_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept && in_item.op == OP_WRITE) begin
          if (fill_drop_r) begin
            if (in_item.last) begin
              fill_drop_nxt = 1'b0;
            end
          end else if (!fill_busy_r && free_head_r == NIL) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res('0, 1'b1, ST_FULL, '0);
            fill_drop_nxt = !in_item.last;
          end else if (!fill_busy_r && lim == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res('0, 1'b1, ST_LONG, '0);
            fill_drop_nxt = !in_item.last;
          end else if (fill_busy_r && LW'(fill_count_r) >= lim) begin
            out_valid_nxt  = 1'b1;
            out_nxt        = mk_res('0, 1'b1, ST_LONG, '0);
            meta_we        = 1'b1;
            meta_waddr     = MA'(fill_block_r);
            meta_wdata     = {free_head_r, CW'(0)};
            free_head_nxt  = fill_block_r;
            fill_busy_nxt  = 1'b0;
            fill_count_nxt = '0;
            fill_drop_nxt  = !in_item.last;
          end else begin
            pay_we         = 1'b1;
            pay_waddr      = pay_addr(blk, fill_count_r);
            fill_block_nxt = blk;
            if (!fill_busy_r) begin
              if (free_head_r == fresh_r) begin
                free_head_nxt = free_head_r + BW'(1);
                fresh_nxt     = fresh_r + BW'(1);
              end else begin
                meta_raddr   = MA'(free_head_r);
                pop_pend_nxt = 1'b1;
                state_nxt    = S_WFIN;
              end
            end
            if (in_item.last) begin
              meta_we        = 1'b1;
              meta_waddr     = MA'(blk);
              meta_wdata     = {NIL, cnt1};
              enq_pend_nxt   = 1'b1;
              enq_len_nxt    = cnt1;
              fill_busy_nxt  = 1'b0;
              fill_count_nxt = '0;
              state_nxt      = S_WFIN;
            end else begin
              fill_busy_nxt  = 1'b1;
              fill_count_nxt = cnt1;
            end
          end
        end else if (accept) begin
          if (in_item.capacity == '0 || in_item.capacity < max_words_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res('0, 1'b1, ST_SMALL, '0);
          end else if (ready_head_r == NIL) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res('0, 1'b1, ST_EMPTY, '0);
          end else begin
            meta_raddr = MA'(ready_head_r);
            rd_blk_nxt = ready_head_r;
            rd_cap_nxt = in_item.capacity;
            state_nxt  = S_RHDR;
          end
        end
      end
      S_WFIN: begin
        if (pop_pend_r) begin
          free_head_nxt = meta_rdata[MW-1:CW];
          pop_pend_nxt  = 1'b0;
        end
        if (enq_pend_r) begin
          if (ready_head_r == NIL) begin
            ready_head_nxt = fill_block_r;
          end else begin
            meta_we    = 1'b1;
            meta_waddr = MA'(ready_tail_r);
            meta_wdata = {fill_block_r, tail_len_r};
          end
          ready_tail_nxt = fill_block_r;
          tail_len_nxt   = enq_len_r;
          enq_pend_nxt   = 1'b0;
          out_valid_nxt  = 1'b1;
          out_nxt        = mk_res('0, 1'b1, ST_OK, enq_len_r);
        end
        state_nxt = S_IDLE;
      end
      S_RHDR: begin
        if (LW'(meta_rdata[CW-1:0]) > LW'(rd_cap_r)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res('0, 1'b1, ST_SMALL, '0);
          state_nxt     = S_IDLE;
        end else begin
          rd_len_nxt  = meta_rdata[CW-1:0];
          rd_link_nxt = meta_rdata[MW-1:CW];
          pay_raddr   = pay_addr(rd_blk_r, '0);
          rd_idx_nxt  = CW'(1);
          rd_cnt_nxt  = '0;
          state_nxt   = S_RSTREAM;
        end
      end
      S_RSTREAM: begin
        out_valid_nxt = 1'b1;
        out_nxt       = mk_res(pay_rdata, rd_final, ST_OK, rd_len_r);
        pay_raddr     = pay_addr(rd_blk_r, rd_idx_r);
        rd_idx_nxt    = rd_idx_r + CW'(1);
        rd_cnt_nxt    = rd_cnt_r + CW'(1);
        if (rd_final) begin
          if (rd_blk_r == ready_tail_r) begin
            ready_head_nxt = NIL;
            ready_tail_nxt = NIL;
          end else begin
            ready_head_nxt = rd_link_r;
          end
          meta_we       = 1'b1;
          meta_waddr    = MA'(rd_blk_r);
          meta_wdata    = {free_head_r, CW'(0)};
          free_head_nxt = rd_blk_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_words_r  <= 5'd16;
      free_head_r  <= '0;
      fresh_r      <= '0;
      ready_head_r <= NIL;
      ready_tail_r <= NIL;
      fill_block_r <= '0;
      fill_count_r <= '0;
      fill_busy_r  <= 1'b0;
      fill_drop_r  <= 1'b0;
      pop_pend_r   <= 1'b0;
      enq_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      max_words_r  <= max_words_nxt;
      free_head_r  <= free_head_nxt;
      fresh_r      <= fresh_nxt;
      ready_head_r <= ready_head_nxt;
      ready_tail_r <= ready_tail_nxt;
      fill_block_r <= fill_block_nxt;
      fill_count_r <= fill_count_nxt;
      fill_busy_r  <= fill_busy_nxt;
      fill_drop_r  <= fill_drop_nxt;
      pop_pend_r   <= pop_pend_nxt;
      enq_pend_r   <= enq_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    tail_len_r <= tail_len_nxt;
    enq_len_r  <= enq_len_nxt;
    rd_blk_r   <= rd_blk_nxt;
    rd_link_r  <= rd_link_nxt;
    rd_len_r   <= rd_len_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    rd_cap_r   <= rd_cap_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTH
  a_ready_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_head_r == NIL) == (ready_tail_r == NIL))
    else $error("ready head and tail disagree on empty");

  a_fill_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fill_busy_r && fill_drop_r))
    else $error("fill and drop both active");

  a_stream_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RSTREAM) |-> (ready_head_r != NIL))
    else $error("streaming from an empty list");

  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WFIN && enq_pend_r) |=> out_valid)
    else $error("closed message gave no beat");
`endif

endmodule
`default_nettype wire

/* src/lbmq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbmq_ram
// Generic single-write, single-read memory with registered read (read-first).
// ----------------------------------------------------------------------------
module lbmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linked-block message queue. A behavioral copy
// of the free list, the readable list and the fill state predicts every
// result beat; a monitor compares each beat with the oldest prediction.
// Covers full and empty pools, too-long messages, small buffers, limit
// changes between phases and random well-formed traffic with noise.
// ----------------------------------------------------------------------------
module tb;
  import lbmq_pkg::*;

  localparam int DEPTH = 16;
  localparam int BWORDS = 16;
  localparam logic [4:0] NONE = 5'(DEPTH);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int errors = 0;
  out_item_t expected_beats[$];

  // predictor state
  logic [4:0] mdl_max;
  logic [4:0] mdl_free_head;
  logic [4:0] mdl_free_link[DEPTH];
  logic [4:0] mdl_ready_head, mdl_ready_tail;
  logic [4:0] mdl_ready_link[DEPTH];
  logic [4:0] mdl_len[DEPTH];
  logic [63:0] mdl_payload[DEPTH*BWORDS];
  logic [4:0] mdl_fill_block, mdl_fill_count;
  logic mdl_fill_busy, mdl_fill_drop;

  linked_block_message_queue u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic out_item_t mk(logic [63:0] w, logic f, status_t s, logic [4:0] l);
    out_item_t r;
    r.word = w; r.final_res = f; r.status = s; r.length = l;
    return r;
  endfunction

  task automatic free_push(input logic [4:0] b);
    if (b < NONE) begin
      mdl_free_link[b[3:0]] = mdl_free_head;
      mdl_free_head = b;
    end
  endtask

  task automatic predict_write(input logic [63:0] d, input logic lst);
    logic [4:0] lim;
    lim = (mdl_max < 5'(BWORDS)) ? mdl_max : 5'(BWORDS);
    if (mdl_fill_drop) begin
      if (lst) mdl_fill_drop = 1'b0;
      return;
    end
    if (!mdl_fill_busy) begin
      if (mdl_free_head >= NONE) begin
        mdl_fill_drop = !lst;
        expected_beats.push_back(mk('0, 1'b1, ST_FULL, '0));
        return;
      end
      mdl_fill_block = mdl_free_head;
      mdl_free_head = mdl_free_link[mdl_fill_block[3:0]];
      mdl_fill_count = '0;
      mdl_fill_busy = 1'b1;
    end
    if (mdl_fill_count >= lim) begin
      free_push(mdl_fill_block);
      mdl_fill_busy = 1'b0;
      mdl_fill_count = '0;
      mdl_fill_drop = !lst;
      expected_beats.push_back(mk('0, 1'b1, ST_LONG, '0));
      return;
    end
    mdl_payload[mdl_fill_block[3:0]*BWORDS + mdl_fill_count] = d;
    mdl_fill_count++;
    if (!lst) return;
    mdl_len[mdl_fill_block[3:0]] = mdl_fill_count;
    mdl_ready_link[mdl_fill_block[3:0]] = NONE;
    if (mdl_ready_head >= NONE || mdl_ready_tail >= NONE) mdl_ready_head = mdl_fill_block;
    else mdl_ready_link[mdl_ready_tail[3:0]] = mdl_fill_block;
    mdl_ready_tail = mdl_fill_block;
    mdl_fill_busy = 1'b0;
    expected_beats.push_back(mk('0, 1'b1, ST_OK, mdl_fill_count));
    mdl_fill_count = '0;
  endtask

  task automatic predict_read(input logic [4:0] cap);
    logic [4:0] b, n;
    if (cap == 0 || cap < mdl_max) begin
      expected_beats.push_back(mk('0, 1'b1, ST_SMALL, '0));
      return;
    end
    if (mdl_ready_head >= NONE) begin
      expected_beats.push_back(mk('0, 1'b1, ST_EMPTY, '0));
      return;
    end
    b = mdl_ready_head;
    n = mdl_len[b[3:0]];
    if (n > cap) begin
      expected_beats.push_back(mk('0, 1'b1, ST_SMALL, '0));
      return;
    end
    for (int i = 0; i < n; i++)
      expected_beats.push_back(mk(mdl_payload[b[3:0]*BWORDS + i], (i + 1 == n), ST_OK, n));
    mdl_ready_head = mdl_ready_link[b[3:0]];
    if (mdl_ready_head >= NONE) begin
      mdl_ready_head = NONE;
      mdl_ready_tail = NONE;
    end
    free_push(b);
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    start <= 1'b0;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge clk);
  endtask

  // one beat into the block
  task automatic send_item(input logic o, input logic [63:0] d, input logic lst,
                           input logic [4:0] cap);
    in_item_t it;
    it.op = o; it.data = d; it.last = lst; it.capacity = cap;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (o == OP_WRITE) predict_write(d, lst);
    else predict_read(cap);
    idle_gap();
  endtask

  task automatic send_msg(input int n);
    for (int i = 0; i < n; i++)
      send_item(OP_WRITE, {$urandom, $urandom}, (i == n - 1), 5'($urandom));
  endtask

  task automatic read_msg(input logic [4:0] cap);
    send_item(OP_READ, {$urandom, $urandom}, 1'($urandom), cap);
  endtask

  task automatic drain();
    int t;
    start <= 1'b0;
    t = 0;
    while (expected_beats.size() != 0 && t < 20000) begin
      @(posedge clk);
      t++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic set_limit(input logic [4:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_max = v;
    @(posedge clk);
  endtask

  task automatic test_directed();
    read_msg(5'd16);
    read_msg(5'd0);
    read_msg(5'd15);
    send_item(OP_WRITE, '1, 1'b1, 5'd31);
    send_item(OP_WRITE, '0, 1'b0, 5'd0);
    send_item(OP_WRITE, 64'h5555_aaaa_5555_aaaa, 1'b1, 5'd0);
    send_msg(16);
    send_msg(17);
    read_msg(5'd31);
    read_msg(5'd16);
    read_msg(5'd16);
  endtask

  task automatic test_full_pool();
    for (int m = 0; m < 17; m++) send_msg(1);
    send_msg(3);
    for (int m = 0; m < 17; m++) read_msg(5'd16);
  endtask

  task automatic test_limits();
    set_limit(5'd4);
    send_msg(4);
    send_msg(5);
    read_msg(5'd3);
    read_msg(5'd4);
    send_msg(4);
    set_limit(5'd1);
    read_msg(5'd1);
    read_msg(5'd4);
    send_msg(1);
    send_msg(2);
    set_limit(5'd0);
    send_msg(1);
    send_msg(2);
    read_msg(5'd0);
    read_msg(5'd1);
    set_limit(5'd31);
    send_msg(3);
    read_msg(5'd30);
    read_msg(5'd31);
    set_limit(5'd16);
    read_msg(5'd16);
  endtask

  task automatic test_random();
    int r;
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_msg($urandom_range(0, 9) == 0 ? 16 : $urandom_range(1, 5));
      else if (r < 85) read_msg($urandom_range(0, 9) == 0 ? 5'($urandom) : 5'd16);
      else if (r < 92) send_msg(17);
      else send_item(1'($urandom), {$urandom, $urandom}, 1'($urandom), 5'($urandom));
    end
    while (mdl_ready_head != NONE) read_msg(5'd16);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: beat with none expected, got %h", $time, out_item);
        errors++;
      end else begin
        out_item_t e;
        e = expected_beats.pop_front();
        if (e.word !== out_item.word || e.final_res !== out_item.final_res ||
            e.status !== out_item.status || e.length !== out_item.length) begin
          $display("%0t: mismatch expected %h got %h", $time, e, out_item);
          errors++;
        end
      end
    end
  end

  initial begin
    mdl_max = 5'd16;
    mdl_free_head = '0;
    for (int i = 0; i < DEPTH; i++) begin
      mdl_free_link[i] = 5'(i + 1);
      mdl_ready_link[i] = '0;
      mdl_len[i] = '0;
    end
    mdl_ready_head = NONE;
    mdl_ready_tail = NONE;
    mdl_fill_block = '0;
    mdl_fill_count = '0;
    mdl_fill_busy = 1'b0;
    mdl_fill_drop = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_pool();
    test_limits();
    test_random();
    drain();
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d beats never arrived", $time, expected_beats.size());
      errors++;
    end
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

/* linked_block_message_queue.f */
src/lbmq_pkg.sv
src/lbmq_ram.sv
src/linked_block_message_queue.sv
dv/tb.sv
